// ----- rtl/ipfwd_pkg.sv -----
// Shared constants, types and control structs of the IPv4 forwarding rewrite.
`timescale 1ns / 1ps
package ipfwd_pkg;

    localparam int ROUTE_ENTRIES = 4;
    localparam int KEY_SLOTS     = 4;
    localparam int MAX_WORDS     = 32768;
    localparam int HDR_DEPTH     = 37;
    localparam int HDR_AW        = 6;
    localparam int POS_W         = 16;
    localparam int SUM_W         = 22;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam logic [2:0]  CFG_MAC_BASE   = 3'd4;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DROP,
        ST_MATCH,
        ST_CSUM,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_FWD
    } t_state;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_INC,
        POS_CLR,
        POS_LOADN
    } t_pos_op;

    typedef struct packed {
        logic    cap;
        t_pos_op pos_op;
        logic    match_en;
        logic    csum_en;
        logic    k_clr;
        logic    k_inc;
        logic    rd_en;
        logic    emit_load;
        logic    fwd_load;
    } t_cmd;

    typedef struct packed {
        logic pos_is6;
        logic pos_is7;
        logic eth_ok;
        logic ihl_ok;
        logic hdr_final;
        logic in_last;
        logic in_sb;
        logic hit_ok;
        logic k_final;
        logic pos_max;
        logic out_free;
        logic frame_last;
    } t_stat;

endpackage

// ----- rtl/ipfwd_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ipfwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ipfwd_ctrl.sv -----
// Frame sequencer: header collection, lookup, header burst, payload pass and drop.
`timescale 1ns / 1ps
module ipfwd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ipfwd_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output ipfwd_pkg::t_cmd  o_cmd
);

    ipfwd_pkg::t_state r_state, n_state;
    logic acc;
    logic bad_hdr;

    assign acc     = i_in_valid && o_in_ready;
    assign bad_hdr = (i_stat.pos_is6 && !i_stat.eth_ok) || (i_stat.pos_is7 && !i_stat.ihl_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipfwd_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipfwd_pkg::ST_COLLECT: begin
                if (acc && bad_hdr && !i_stat.in_last) begin
                    n_state = ipfwd_pkg::ST_DROP;
                end else if (acc && !bad_hdr && i_stat.hdr_final && !i_stat.in_sb) begin
                    n_state = ipfwd_pkg::ST_MATCH;
                end
            end
            ipfwd_pkg::ST_DROP: begin
                if (acc && i_stat.in_last) begin
                    n_state = ipfwd_pkg::ST_COLLECT;
                end
            end
            ipfwd_pkg::ST_MATCH: n_state = ipfwd_pkg::ST_CSUM;
            ipfwd_pkg::ST_CSUM: begin
                if (i_stat.hit_ok) begin
                    n_state = ipfwd_pkg::ST_EMIT_RD;
                end else if (i_stat.frame_last) begin
                    n_state = ipfwd_pkg::ST_COLLECT;
                end else begin
                    n_state = ipfwd_pkg::ST_DROP;
                end
            end
            ipfwd_pkg::ST_EMIT_RD: n_state = ipfwd_pkg::ST_EMIT_WR;
            ipfwd_pkg::ST_EMIT_WR: begin
                if (i_stat.out_free) begin
                    if (!i_stat.k_final) begin
                        n_state = ipfwd_pkg::ST_EMIT_RD;
                    end else if (i_stat.frame_last) begin
                        n_state = ipfwd_pkg::ST_COLLECT;
                    end else begin
                        n_state = ipfwd_pkg::ST_FWD;
                    end
                end
            end
            ipfwd_pkg::ST_FWD: begin
                if (acc && i_stat.in_last) begin
                    n_state = ipfwd_pkg::ST_COLLECT;
                end else if (acc && i_stat.pos_max) begin
                    n_state = ipfwd_pkg::ST_DROP;
                end
            end
            default: n_state = ipfwd_pkg::ST_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pos_op = ipfwd_pkg::POS_HOLD;
        case (r_state)
            ipfwd_pkg::ST_COLLECT: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = acc;
                if (acc) begin
                    if (bad_hdr || (!i_stat.hdr_final && i_stat.in_last)
                        || (i_stat.hdr_final && i_stat.in_sb)) begin
                        o_cmd.pos_op = ipfwd_pkg::POS_CLR;
                    end else if (!i_stat.hdr_final) begin
                        o_cmd.pos_op = ipfwd_pkg::POS_INC;
                    end
                end
            end
            ipfwd_pkg::ST_DROP: o_in_ready = 1'b1;
            ipfwd_pkg::ST_MATCH: o_cmd.match_en = 1'b1;
            ipfwd_pkg::ST_CSUM: begin
                if (i_stat.hit_ok) begin
                    o_cmd.csum_en = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                end else begin
                    o_cmd.pos_op = ipfwd_pkg::POS_CLR;
                end
            end
            ipfwd_pkg::ST_EMIT_RD: o_cmd.rd_en = 1'b1;
            ipfwd_pkg::ST_EMIT_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (!i_stat.k_final) begin
                        o_cmd.k_inc = 1'b1;
                    end else if (i_stat.frame_last) begin
                        o_cmd.pos_op = ipfwd_pkg::POS_CLR;
                    end else begin
                        o_cmd.pos_op = ipfwd_pkg::POS_LOADN;
                    end
                end
            end
            ipfwd_pkg::ST_FWD: begin
                o_in_ready     = i_stat.out_free;
                o_cmd.fwd_load = acc;
                if (acc) begin
                    if (i_stat.in_last || i_stat.pos_max) begin
                        o_cmd.pos_op = ipfwd_pkg::POS_CLR;
                    end else begin
                        o_cmd.pos_op = ipfwd_pkg::POS_INC;
                    end
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// ----- rtl/ipfwd_dp.sv -----
// Datapath: route table, header store, checksum and output word register.
`timescale 1ns / 1ps
module ipfwd_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_wdata,
    input  logic [15:0]      i_frame_word,
    input  logic             i_word_last,
    input  logic             i_single_byte,
    input  logic             i_out_ready,
    input  ipfwd_pkg::t_cmd  i_cmd,
    output ipfwd_pkg::t_stat o_stat,
    output logic             o_out_valid,
    output logic [15:0]      o_out_word,
    output logic             o_out_last,
    output logic             o_out_single_byte
);

    logic [63:0] r_key [ipfwd_pkg::KEY_SLOTS];
    logic [47:0] r_mac [ipfwd_pkg::KEY_SLOTS];

    logic [ipfwd_pkg::POS_W-1:0]  r_pos;
    logic [ipfwd_pkg::HDR_AW-1:0] r_n;
    logic [ipfwd_pkg::HDR_AW-1:0] r_k;
    logic                         r_last;
    logic [15:0]                  r_w11;
    logic [31:0]                  r_src, r_dst;
    logic [ipfwd_pkg::SUM_W-1:0]  r_sum;
    logic [1:0]                   r_hit;
    logic                         r_hit_ok;
    logic [15:0]                  r_csum, r_w11n;
    logic [31:0]                  r_nsrc;
    logic [47:0]                  r_dmac, r_smac;
    logic                         r_ov, r_ol, r_os;
    logic [15:0]                  r_ow;

    logic [15:0]                  ram_rdata;
    logic [ipfwd_pkg::POS_W-1:0]  pos_inc;
    logic [1:0]                   hit;
    logic                         hit_any;
    logic [1:0]                   nxt;
    logic [15:0]                  w11n;
    logic [31:0]                  nsrc;
    logic [ipfwd_pkg::SUM_W-1:0]  total;
    logic [16:0]                  fold1;
    logic [15:0]                  fold2;
    logic [15:0]                  emit_word;
    logic                         out_free;
    logic                         skip_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ipfwd_pkg::KEY_SLOTS; i++) begin
                r_key[i] <= '0;
                r_mac[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx < ipfwd_pkg::CFG_MAC_BASE) begin
                r_key[i_cfg_idx[1:0]] <= i_cfg_wdata;
            end else begin
                r_mac[i_cfg_idx[1:0]] <= i_cfg_wdata[47:0];
            end
        end
    end

    ipfwd_ram #(
        .WIDTH (16),
        .DEPTH (ipfwd_pkg::HDR_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cap),
        .i_waddr (r_pos[ipfwd_pkg::HDR_AW-1:0]),
        .i_wdata (i_frame_word),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_k),
        .o_rdata (ram_rdata)
    );

    assign pos_inc = r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            case (i_cmd.pos_op)
                ipfwd_pkg::POS_INC:   r_pos <= pos_inc;
                ipfwd_pkg::POS_CLR:   r_pos <= '0;
                ipfwd_pkg::POS_LOADN: r_pos <= {{(ipfwd_pkg::POS_W-ipfwd_pkg::HDR_AW){1'b0}}, r_n};
                default:              r_pos <= r_pos;
            endcase
        end
    end

    // words 11..14 stay out of the running sum; the rewritten 11, 13 and 14 join it at the end
    assign skip_sum = (r_pos == 16'd11) || (r_pos == 16'd12)
                   || (r_pos == 16'd13) || (r_pos == 16'd14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.cap && r_pos == 16'd7) begin
            r_n <= ipfwd_pkg::HDR_AW'(7 + 2 * i_frame_word[11:8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_last <= i_word_last;
            if (r_pos == 16'd0) begin
                r_sum <= '0;
            end else if (r_pos >= 16'd7 && !skip_sum) begin
                r_sum <= r_sum + ipfwd_pkg::SUM_W'(i_frame_word);
            end
            if (r_pos == 16'd11) r_w11 <= i_frame_word;
            if (r_pos == 16'd13) r_src[31:16] <= i_frame_word;
            if (r_pos == 16'd14) r_src[15:0]  <= i_frame_word;
            if (r_pos == 16'd15) r_dst[31:16] <= i_frame_word;
            if (r_pos == 16'd16) r_dst[15:0]  <= i_frame_word;
        end
    end

    // lowest matching entry wins
    always_comb begin
        hit     = '0;
        hit_any = 1'b0;
        for (int i = ipfwd_pkg::ROUTE_ENTRIES - 1; i >= 0; i--) begin
            if (r_key[i] == {r_src, r_dst}) begin
                hit     = 2'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match_en) begin
            r_hit    <= hit;
            r_hit_ok <= hit_any && (32'(hit) + 32'd1 < 32'(ipfwd_pkg::ROUTE_ENTRIES));
        end
    end

    assign nxt   = r_hit + 2'd1;
    assign nsrc  = r_key[nxt][63:32];
    assign w11n  = {r_w11[15:8] - 8'd1, r_w11[7:0]};
    assign total = r_sum + ipfwd_pkg::SUM_W'(w11n) + ipfwd_pkg::SUM_W'(nsrc[31:16])
                 + ipfwd_pkg::SUM_W'(nsrc[15:0]);
    assign fold1 = 17'(total[ipfwd_pkg::SUM_W-1:16]) + 17'(total[15:0]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.csum_en) begin
            r_csum <= ~fold2;
            r_w11n <= w11n;
            r_nsrc <= nsrc;
            r_dmac <= r_mac[nxt];
            r_smac <= r_mac[r_hit];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_comb begin
        case (r_k)
            6'd0:    emit_word = r_dmac[47:32];
            6'd1:    emit_word = r_dmac[31:16];
            6'd2:    emit_word = r_dmac[15:0];
            6'd3:    emit_word = r_smac[47:32];
            6'd4:    emit_word = r_smac[31:16];
            6'd5:    emit_word = r_smac[15:0];
            6'd6:    emit_word = ipfwd_pkg::ETHERTYPE_IPV4;
            6'd11:   emit_word = r_w11n;
            6'd12:   emit_word = r_csum;
            6'd13:   emit_word = r_nsrc[31:16];
            6'd14:   emit_word = r_nsrc[15:0];
            default: emit_word = ram_rdata;
        endcase
    end

    assign out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.fwd_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_ow <= emit_word;
            r_ol <= r_last && o_stat.k_final;
            r_os <= 1'b0;
        end else if (i_cmd.fwd_load) begin
            r_ow <= i_frame_word;
            r_ol <= i_word_last || o_stat.pos_max;
            r_os <= i_word_last && i_single_byte;
        end
    end

    always_comb begin
        o_stat.pos_is6    = (r_pos == 16'd6);
        o_stat.pos_is7    = (r_pos == 16'd7);
        o_stat.eth_ok     = (i_frame_word == ipfwd_pkg::ETHERTYPE_IPV4);
        o_stat.ihl_ok     = (i_frame_word[11:8] >= ipfwd_pkg::IHL_MIN);
        o_stat.hdr_final  = (r_pos > 16'd7)
                          && (pos_inc >= {{(ipfwd_pkg::POS_W-ipfwd_pkg::HDR_AW){1'b0}}, r_n});
        o_stat.in_last    = i_word_last;
        o_stat.in_sb      = i_word_last && i_single_byte;
        o_stat.hit_ok     = r_hit_ok;
        o_stat.k_final    = (r_k + 1'b1 == r_n);
        o_stat.pos_max    = (32'(pos_inc) >= 32'(ipfwd_pkg::MAX_WORDS));
        o_stat.out_free   = out_free;
        o_stat.frame_last = r_last;
    end

    assign o_out_valid       = r_ov;
    assign o_out_word        = r_ow;
    assign o_out_last        = r_ol;
    assign o_out_single_byte = r_os;

endmodule

// ----- rtl/ipv4_forward_header_rewrite.sv -----
// Top level of the IPv4 forwarding header rewrite.
// Header words are taken one per cycle; after the last header word the lookup and
// checksum states follow, then the n-word header leaves word by word, each word a
// registered header RAM read and then an output register load, held while stalled.
// Payload then passes at one word per cycle through the output register if free.
// Synchronous active-low reset returns to header collection with no word pending.
`timescale 1ns / 1ps
module ipv4_forward_header_rewrite (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_frame_word,
    input  logic        i_word_last,
    input  logic        i_single_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_word,
    output logic        o_out_last,
    output logic        o_out_single_byte
);

    ipfwd_pkg::t_cmd  cmd;
    ipfwd_pkg::t_stat stat;

    ipfwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ipfwd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_frame_word      (i_frame_word),
        .i_word_last       (i_word_last),
        .i_single_byte     (i_single_byte),
        .i_out_ready       (i_out_ready),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_out_word        (o_out_word),
        .o_out_last        (o_out_last),
        .o_out_single_byte (o_out_single_byte)
    );

endmodule

// ----- rtl/ipfwd_chk.sv -----
// Port-level checks for the forwarding rewrite, bound to the top level.
`timescale 1ns / 1ps
module ipfwd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_word,
    input logic        o_out_last,
    input logic        o_out_single_byte
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word)
        && $stable(o_out_last))
        else $error("output word changed while stalled");

    a_sb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_single_byte |-> o_out_last)
        else $error("single byte flag on a word that is not last");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // after reset the block waits for a header word
    a_rst_rdy: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

endmodule

bind ipv4_forward_header_rewrite ipfwd_chk u_ipfwd_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_out_word        (o_out_word),
    .o_out_last        (o_out_last),
    .o_out_single_byte (o_out_single_byte)
);
